FILE: src/gfpd_pkg.sv
// ----------------------------------------------------------------------------
// gfpd_pkg
// Shared types, constants and the GF(2^8) multiply for the polynomial divider.
// ----------------------------------------------------------------------------
package gfpd_pkg;

  localparam int MAX_REM_LEN = 16;
  localparam int SYM_W       = 8;
  localparam int POLY_W      = 9;
  localparam int DLEN_W      = 8;
  localparam int RLEN_W      = 5;
  localparam int COEF_W      = 64;
  localparam int CFG_IDX_W   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_POLY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REM_LEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFS_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFS_HIGH  = 3'd4;

  localparam logic [POLY_W-1:0] PRIME_POLY_RST = 9'd285;
  localparam logic [DLEN_W-1:0] DIV_LEN_RST    = 8'd255;
  localparam logic [RLEN_W-1:0] REM_LEN_RST    = 5'd16;

  typedef logic [SYM_W-1:0] sym_t;

  // per-cell control, driven from the top level each cycle
  typedef struct packed {
    logic upd;        // cell takes a new value this cycle
    logic take_next;  // neighbor value is part of the divisor window
    logic feed;       // quotient phase: add coef * feedback
    logic clr;        // end of dividend or length error
  } gfpd_cell_ctrl_t;

  // shift-and-add multiply, reduction by the low byte of the polynomial
  function automatic sym_t gf_mul(input sym_t a, input sym_t b, input sym_t red);
    sym_t acc;
    sym_t x;
    acc = '0;
    x   = a;
    for (int k = 0; k < SYM_W; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      if (x[SYM_W-1]) begin
        x = {x[SYM_W-2:0], 1'b0} ^ red;
      end else begin
        x = {x[SYM_W-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

FILE: src/gfpd_cell.sv
// ----------------------------------------------------------------------------
// gfpd_cell
// One LFSR stage: holds a feedback symbol, takes its neighbor's plus a product.
// ----------------------------------------------------------------------------
module gfpd_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gfpd_pkg::gfpd_cell_ctrl_t ctrl,
  input  gfpd_pkg::sym_t            value,
  input  gfpd_pkg::sym_t            coef,
  input  gfpd_pkg::sym_t            red,
  input  gfpd_pkg::sym_t            next_in,
  output gfpd_pkg::sym_t            fb
);

  gfpd_pkg::sym_t fb_r;
  gfpd_pkg::sym_t fb_nxt;
  gfpd_pkg::sym_t shifted;
  gfpd_pkg::sym_t prod;

  always_comb begin
    shifted = ctrl.take_next ? next_in : '0;
    prod    = ctrl.feed ? gfpd_pkg::gf_mul(coef, value, red) : '0;
    if (ctrl.clr) begin
      fb_nxt = '0;
    end else if (ctrl.upd) begin
      fb_nxt = shifted ^ prod;
    end else begin
      fb_nxt = fb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= '0;
    end else begin
      fb_r <= fb_nxt;
    end
  end

  assign fb = fb_r;

endmodule

FILE: src/gf256_polynomial_divider_core.sv
// ----------------------------------------------------------------------------
// gf256_polynomial_divider_core
// Streaming synthetic division of a GF(2^8) dividend by a monic divisor.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_dividend_symbol[7:0]
//  out     | output    | out_valid/out_ready| out_symbol, out_is_remainder,
//          |           |                    | out_last, out_length_error
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index[2:0], cfg_data[63:0]
//
//  One symbol per cycle: the whole LFSR update happens in the transfer cycle,
//  set by the GF multiply in each cell; the result shows in the next cycle.
//  The output register frees as it is taken, so input transfers continue
//  while the result side drains. A stall on out holds in_ready low.
//  Reset (rst_n low, synchronous) restores the configuration defaults,
//  clears every feedback cell, the symbol position and the output valid.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module gf256_polynomial_divider_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input symbols
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gfpd_pkg::SYM_W-1:0]          in_dividend_symbol,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gfpd_pkg::SYM_W-1:0]          out_symbol,
  output logic                                out_is_remainder,
  output logic                                out_last,
  output logic                                out_length_error,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gfpd_pkg::COEF_W-1:0]         cfg_data
);

  localparam int N = gfpd_pkg::MAX_REM_LEN;

  // configuration registers
  logic [gfpd_pkg::POLY_W-1:0] poly_r;
  logic [gfpd_pkg::DLEN_W-1:0] dlen_r;
  logic [gfpd_pkg::RLEN_W-1:0] rlen_r;
  logic [gfpd_pkg::COEF_W-1:0] coef_lo_r;
  logic [gfpd_pkg::COEF_W-1:0] coef_hi_r;

  // stream state
  logic [gfpd_pkg::DLEN_W-1:0] pos_r;
  logic [gfpd_pkg::DLEN_W-1:0] pos_nxt;

  // output register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  gfpd_pkg::sym_t       out_sym_r;
  logic                 out_rem_r;
  logic                 out_last_r;
  logic                 out_err_r;

  gfpd_pkg::sym_t       fb     [N];
  gfpd_pkg::sym_t       coefs  [N];

  logic                 accept;
  logic                 len_err;
  logic                 is_last;
  logic                 rem_phase;
  logic [gfpd_pkg::DLEN_W-1:0] n_minus_r;
  gfpd_pkg::sym_t       head;
  gfpd_pkg::sym_t       value;
  gfpd_pkg::sym_t       red;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign red       = poly_r[gfpd_pkg::SYM_W-1:0];

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r    <= gfpd_pkg::PRIME_POLY_RST;
      dlen_r    <= gfpd_pkg::DIV_LEN_RST;
      rlen_r    <= gfpd_pkg::REM_LEN_RST;
      coef_lo_r <= '0;
      coef_hi_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gfpd_pkg::CFG_PRIME_POLY: poly_r    <= cfg_data[gfpd_pkg::POLY_W-1:0];
        gfpd_pkg::CFG_DIV_LEN:    dlen_r    <= cfg_data[gfpd_pkg::DLEN_W-1:0];
        gfpd_pkg::CFG_REM_LEN:    rlen_r    <= cfg_data[gfpd_pkg::RLEN_W-1:0];
        gfpd_pkg::CFG_COEFS_LOW:  coef_lo_r <= cfg_data;
        gfpd_pkg::CFG_COEFS_HIGH: coef_hi_r <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---- phase decode ----
  always_comb begin
    len_err   = (rlen_r > gfpd_pkg::RLEN_W'(N)) ||
                (dlen_r <= {{(gfpd_pkg::DLEN_W-gfpd_pkg::RLEN_W){1'b0}}, rlen_r});
    is_last   = ({1'b0, pos_r} + 9'd1) >= {1'b0, dlen_r};
    n_minus_r = dlen_r - {{(gfpd_pkg::DLEN_W-gfpd_pkg::RLEN_W){1'b0}}, rlen_r};
    rem_phase = is_last || (pos_r >= n_minus_r);
    // degree-zero divisor has no head cell
    head      = (rlen_r != '0) ? fb[0] : '0;
    value     = in_dividend_symbol ^ head;
  end

  // ---- cell chain ----
  for (genvar k = 0; k < N; k++) begin : g_cell
    gfpd_pkg::gfpd_cell_ctrl_t ctrl;
    gfpd_pkg::sym_t            nbr;

    // coefficient k+1: low word holds 1..8, high word 9..16
    if (k < 8) begin : g_lo
      assign coefs[k] = coef_lo_r[8*k +: 8];
    end else begin : g_hi
      assign coefs[k] = coef_hi_r[8*(k-8) +: 8];
    end

    if (k == N-1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = fb[k+1];
    end

    // cells past the divisor degree hold their contents until a clear
    assign ctrl.upd       = accept && !len_err && (gfpd_pkg::RLEN_W'(k) < rlen_r);
    assign ctrl.take_next = gfpd_pkg::RLEN_W'(k+1) < rlen_r;
    assign ctrl.feed      = !rem_phase;
    assign ctrl.clr       = accept && (len_err || is_last);

    gfpd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .value   (value),
      .coef    (coefs[k]),
      .red     (red),
      .next_in (nbr),
      .fb      (fb[k])
    );
  end

  // ---- symbol position ----
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (len_err || is_last) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // ---- output register ----
  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_sym_r  <= len_err ? '0 : value;
      out_rem_r  <= !len_err && rem_phase;
      out_last_r <= !len_err && is_last;
      out_err_r  <= len_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_sym_r;
  assign out_is_remainder = out_rem_r;
  assign out_last         = out_last_r;
  assign out_length_error = out_err_r;

endmodule

FILE: src/gfpd_checker.sv
// ----------------------------------------------------------------------------
// gfpd_checker
// Port-level checks on the divider core, bound to the top level.
// ----------------------------------------------------------------------------
module gfpd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [gfpd_pkg::SYM_W-1:0]   out_symbol,
  input logic                         out_is_remainder,
  input logic                         out_last,
  input logic                         out_length_error
);

  // no result may appear right out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
    $stable(out_is_remainder) && $stable(out_last) && $stable(out_length_error))
    else $error("stalled result changed");

  // a blocked output register blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // error results carry nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_error |->
    out_symbol == '0 && !out_is_remainder && !out_last)
    else $error("length error result not clean");

  // the final symbol is always a remainder symbol
  a_last_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_is_remainder)
    else $error("last result not marked remainder");

endmodule

bind gf256_polynomial_divider_core gfpd_checker u_gfpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_symbol       (out_symbol),
  .out_is_remainder (out_is_remainder),
  .out_last         (out_last),
  .out_length_error (out_length_error)
);
